FILE: design/swa_pkg.sv
// Shared types and constants for the sliding window average unit.
`timescale 1ns / 1ps
`default_nettype none

package swa_pkg;

  // Default store depth and sample width
  localparam int unsigned WINDOW_MAX_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Window length register and kept count width
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] WIN_RESET = 7'd16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic sum_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: design/swa_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module swa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/swa_ctrl.sv
// Controller state machine for the sliding window average unit.
`timescale 1ns / 1ps
`default_nettype none

module swa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire swa_pkg::status_t status_i,
  output swa_pkg::cmd_t        cmd_o
);

  swa_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pick the next state and drive the commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = swa_pkg::ST_SUM;
        end
      end
      swa_pkg::ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (status_i.sum_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = swa_pkg::ST_DIV;
        end
      end
      swa_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = swa_pkg::ST_DONE;
        end
      end
      swa_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = swa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/swa_dp.sv
// Datapath: sample store, window count, summing loop, serial divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module swa_dp #(
  parameter int unsigned WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swa_pkg::LEN_W-1:0]       cfg_data_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]        average_o,
  output logic [swa_pkg::LEN_W-1:0]            kept_count_o,
  output logic                                 valid_res_o,
  input  wire swa_pkg::cmd_t                   cmd_i,
  output swa_pkg::status_t                     status_o
);

  localparam int unsigned LW    = swa_pkg::LEN_W;
  localparam int unsigned AW    = $clog2(WINDOW_MAX);
  localparam int unsigned SUM_W = SAMPLE_BITS + LW;
  localparam int unsigned CW    = $clog2(SUM_W + 1);
  localparam int unsigned LEN_MAX = (1 << LW) - 1;
  localparam int unsigned WIN_CAP = (WINDOW_MAX < LEN_MAX) ? WINDOW_MAX : LEN_MAX;
  localparam logic [LW-1:0] WinCap   = LW'(WIN_CAP);
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_MAX - 1);
  localparam logic [CW-1:0] DivSteps = CW'(SUM_W);

  logic [LW-1:0]            win_len_q;
  logic [AW-1:0]            newest_q;
  logic [LW-1:0]            stored_q;
  logic [AW-1:0]            rd_ptr_q;
  logic [LW-1:0]            rem_cnt_q;
  logic                     rd_pend_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     neg_q;
  logic [SUM_W-1:0]         quo_q;
  logic [LW-1:0]            rmd_q;
  logic [CW-1:0]            div_cnt_q;
  logic                     out_valid_q;
  logic signed [SAMPLE_BITS-1:0] avg_q;
  logic [LW-1:0]            kept_q;

  logic [LW-1:0]            win_cap;
  logic [AW-1:0]            slot_next;
  logic [AW-1:0]            ptr_prev;
  logic [LW:0]              cnt_inc;
  logic [LW-1:0]            cnt_new;
  logic                     rd_issue;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [SUM_W-1:0]         sum_mag;
  logic [LW:0]              rmd_sh;
  logic [LW:0]              rmd_sub;
  logic                     quo_bit;
  logic [SAMPLE_BITS-1:0]   quo_low;
  logic signed [SAMPLE_BITS-1:0] avg_val;

  // Saturate the window and advance slot pointers
  always_comb begin
    win_cap   = (win_len_q > WinCap) ? WinCap : win_len_q;
    slot_next = (newest_q == LastSlot) ? '0 : newest_q + AW'(1);
    ptr_prev  = (rd_ptr_q == '0) ? LastSlot : rd_ptr_q - AW'(1);
    cnt_inc   = {1'b0, stored_q} + (LW+1)'(1);
    cnt_new   = (cnt_inc > {1'b0, win_cap}) ? win_cap : cnt_inc[LW-1:0];
    rd_issue  = cmd_i.sum_step && (rem_cnt_q != '0);
  end

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (slot_next),
    .wdata_i (sample_i),
    .re_i    (rd_issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  // Window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= swa_pkg::WIN_RESET;
    end else if (cfg_we_i) begin
      win_len_q <= cfg_data_i;
    end
  end

  // Newest slot and kept count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      stored_q <= '0;
    end else if (cmd_i.accept) begin
      newest_q <= slot_next;
      stored_q <= cnt_new;
    end
  end

  // Walk back from the newest slot, one read per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_cnt_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_issue;
      if (cmd_i.accept) begin
        rem_cnt_q <= cnt_new;
      end else if (rd_issue) begin
        rem_cnt_q <= rem_cnt_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_ptr_q <= slot_next;
    end else if (rd_issue) begin
      rd_ptr_q <= ptr_prev;
    end
  end

  // Accumulate returned samples
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sum_q <= '0;
    end else if (rd_pend_q) begin
      sum_q <= sum_q + SUM_W'($signed(rd_data));
    end
  end

  // Restoring divide of the sum magnitude by the kept count
  always_comb begin
    sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    rmd_sh  = {rmd_q, quo_q[SUM_W-1]};
    rmd_sub = rmd_sh - {1'b0, stored_q};
    quo_bit = (rmd_sh >= {1'b0, stored_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DivSteps;
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      div_cnt_q <= div_cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= sum_mag;
      rmd_q <= '0;
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      quo_q <= {quo_q[SUM_W-2:0], quo_bit};
      rmd_q <= quo_bit ? rmd_sub[LW-1:0] : rmd_sh[LW-1:0];
    end
  end

  // Apply the sign; an empty window averages to zero
  always_comb begin
    quo_low = quo_q[SAMPLE_BITS-1:0];
    if (stored_q == '0) begin
      avg_val = '0;
    end else if (neg_q) begin
      avg_val = $signed(-quo_low);
    end else begin
      avg_val = $signed(quo_low);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      avg_q  <= avg_val;
      kept_q <= stored_q;
    end
  end

  assign status_o.sum_done = (rem_cnt_q == '0) && !rd_pend_q;
  assign status_o.div_done = (div_cnt_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign average_o    = avg_q;
  assign kept_count_o = kept_q;
  assign valid_res_o  = (kept_q != '0);

endmodule

`default_nettype wire

FILE: design/sliding_window_average_unit.sv
// Top level of the sliding window average unit (moving average filter).
// Each accepted word is a signed Q8.8 sample that goes into a ring store of
// WINDOW_MAX entries; the result word gives the mean of the newest kept
// samples (truncated toward zero), the kept count and a flag that is set when
// at least one sample is kept. The window length register resets to 16 and
// saturates at WINDOW_MAX; a window of zero yields count 0, flag 0, mean 0.
// A new word is taken only once the last is through: the sum walks the store
// through its single read port, one entry per cycle, and a restoring divider
// then makes one quotient bit per cycle. A finished result waits in the
// output register while the next word is accepted. No clearing pass follows
// reset.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_average_unit #(
  parameter int unsigned WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swa_pkg::LEN_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      average_o,
  output logic [swa_pkg::LEN_W-1:0]          kept_count_o,
  output logic                               valid_res_o
);

  swa_pkg::cmd_t    cmd;
  swa_pkg::status_t status;

  swa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swa_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (sample_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .average_o    (average_o),
    .kept_count_o (kept_count_o),
    .valid_res_o  (valid_res_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

`default_nettype wire

FILE: design/swa_checker.sv
// Port-level checks for the sliding window average unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module swa_checker #(
  parameter int unsigned WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [SAMPLE_BITS-1:0] average_o,
  input wire logic [swa_pkg::LEN_W-1:0]     kept_count_o,
  input wire logic                          valid_res_o
);

  // Flag follows the kept count
  a_flag_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_res_o == (kept_count_o != '0)))
    else $error("valid_res disagrees with kept_count");

  // Empty window gives a zero mean
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (average_o == '0))
    else $error("nonzero average with no kept samples");

  // Kept count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(kept_count_o) <= int'(WINDOW_MAX)))
    else $error("kept_count beyond store depth");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(average_o) && $stable(kept_count_o)))
    else $error("result word changed while stalled");

endmodule

bind sliding_window_average_unit swa_checker #(
  .WINDOW_MAX  (WINDOW_MAX),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .average_o    (average_o),
  .kept_count_o (kept_count_o),
  .valid_res_o  (valid_res_o)
);

`default_nettype wire

FILE: tb/swa_window_checker.sv
// Checker for the sliding window average unit: predicts and compares results.
`timescale 1ns / 1ps

module swa_window_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [swa_pkg::LEN_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [15:0]               sample_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [15:0]               average_i,
  input  logic [swa_pkg::LEN_W-1:0]        kept_count_i,
  input  logic                             valid_res_i,
  output int unsigned                      pending_o,
  output int unsigned                      errors_o
);

  import swa_pkg::*;

  localparam int RING_DEPTH = WINDOW_MAX_DEF;

  typedef struct packed {
    logic signed [15:0] average;
    logic [LEN_W-1:0]   kept_count;
    logic               valid_res;
  } window_result_t;

  // Shadow copy of the block state and its window register
  logic signed [15:0] sample_ring [RING_DEPTH];
  int                 newest_slot;
  int                 kept_total;
  logic [LEN_W-1:0]   window_len;
  window_result_t     mean_queue [$];

  initial errors_o = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: window average mismatch on %s: got %0d, expected %0d",
             $realtime, what, got, want);
    errors_o++;
  endtask

  // Store the new sample, drop the excess oldest ones, and form the mean
  task automatic advance_window(input logic signed [15:0] sample, output window_result_t res);
    int     limit;
    int     slot;
    longint total;
    longint mean;
    limit = (window_len > RING_DEPTH) ? RING_DEPTH : int'(window_len);
    newest_slot = (newest_slot + 1 >= RING_DEPTH) ? 0 : newest_slot + 1;
    sample_ring[newest_slot] = sample;
    kept_total = (kept_total + 1 > limit) ? limit : kept_total + 1;
    total = 0;
    slot = newest_slot;
    for (int k = 0; k < kept_total; k++) begin
      total += longint'(sample_ring[slot]);
      slot = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
    end
    mean = (kept_total != 0) ? total / longint'(kept_total) : 0;
    res.average    = mean[15:0];
    res.kept_count = kept_total[LEN_W-1:0];
    res.valid_res  = (kept_total != 0);
  endtask

  // Follow register writes and both channels at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t want;
    if (!rst_ni) begin
      newest_slot = 0;
      kept_total  = 0;
      window_len  = WIN_RESET;
      mean_queue.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        window_len = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (mean_queue.size() == 0) begin
          report_mismatch("unexpected result word (queue size)", 1, 0);
        end else begin
          want = mean_queue.pop_front();
          if (average_i !== want.average)
            report_mismatch("average", average_i, want.average);
          if (kept_count_i !== want.kept_count)
            report_mismatch("kept_count", kept_count_i, want.kept_count);
          if (valid_res_i !== want.valid_res)
            report_mismatch("valid_res", valid_res_i, want.valid_res);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_window(sample_i, want);
        mean_queue.push_back(want);
      end
      pending_o <= mean_queue.size();
    end
  end

endmodule

FILE: tb/tb_sliding_window_average_unit.sv
// Testbench top for the sliding window average unit: stimulus and verdict.
`timescale 1ns / 1ps

module tb_sliding_window_average_unit;

  import swa_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_GAP      = 40;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [LEN_W-1:0]        cfg_data_i   = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic signed [15:0]      sample_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic signed [15:0]      average_o;
  logic [LEN_W-1:0]        kept_count_o;
  logic                    valid_res_o;

  int unsigned pending_words;
  int unsigned mismatch_count;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  sliding_window_average_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .average_o    (average_o),
    .kept_count_o (kept_count_o),
    .valid_res_o  (valid_res_o)
  );

  swa_window_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .average_i    (average_o),
    .kept_count_i (kept_count_o),
    .valid_res_i  (valid_res_o),
    .pending_o    (pending_words),
    .errors_o     (mismatch_count)
  );

  always #10 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when neither channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_sliding_window_average_unit: FAIL");
      $finish;
    end
  end

  // Offer one sample word after a random gap and hold it until accepted
  task automatic push_sample(input logic signed [15:0] value);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the window length while the block is idle
  task automatic set_window(input logic [LEN_W-1:0] len);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mix extremes, small values and full random words; flavor biases the sign
  function automatic logic signed [15:0] pick_sample(input int flavor);
    logic signed [15:0] v;
    case ($urandom_range(9))
      0: v = 16'sh7fff;
      1: v = -16'sh8000;
      2: v = 16'($urandom_range(511)) - 16'sd256;
      default: v = 16'($urandom);
    endcase
    if (flavor == 1) v[15] = 1'b0;
    if (flavor == 2) v[15] = 1'b1;
    return v;
  endfunction

  initial begin
    logic [LEN_W-1:0] len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes at the reset window of 16
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(-16'sh8000);
    push_sample(-16'sh8000);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_sample(16'sd0);
    push_sample(16'sh5555);
    // Window above the store depth saturates
    set_window(7'd127);
    repeat (4) push_sample(-16'sh8000);
    // Shrunk window drops many old samples in one step
    set_window(7'd2);
    push_sample(16'sd3);
    push_sample(-16'sd7);
    push_sample(16'sh2aaa);
    // Zero window keeps nothing
    set_window(7'd0);
    push_sample(16'sh7fff);
    push_sample(-16'sd5);
    // Grow again from an empty store
    set_window(7'd1);
    push_sample(-16'sd3);
    push_sample(16'sd9);
    set_window(7'd64);
    repeat (4) push_sample(16'sh7fff);

    // Random: each block runs two window settings under one idling mode
    for (int blk = 0; blk < 8; blk++) begin
      for (int half = 0; half < 2; half++) begin
        int flavor;
        case ($urandom_range(6))
          0: len = 7'd0;
          1: len = 7'd1;
          2: len = 7'd64;
          3: len = 7'd127;
          4: len = 7'($urandom_range(127, 65));
          5: len = 7'($urandom_range(63, 2));
          default: len = 7'($urandom_range(16, 2));
        endcase
        set_window(len);
        case (blk % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
          default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
        flavor = $urandom_range(3);
        repeat (40) push_sample(pick_sample(flavor));
      end
    end

    drain_results();
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("tb_sliding_window_average_unit: PASS");
    end else begin
      $display("tb_sliding_window_average_unit: FAIL");
    end
    $finish;
  end

endmodule
